// File: src/cpc_pkg.sv
// Package for the CSI parameter collector: slot counts, widths, byte codes,
// the word and command/status structs, and the byte classifier.
// No dependencies.
package cpc_pkg;

	// Slot counts
	localparam int PARAM_SLOTS        = 4;
	localparam int SUB_SLOTS          = 4;
	localparam int INTERMEDIATE_SLOTS = 4;

	// Counter widths hold 0..SLOTS; index widths address one slot
	localparam int PCNT_W = $clog2(PARAM_SLOTS + 1);
	localparam int SCNT_W = $clog2(SUB_SLOTS + 1);
	localparam int ICNT_W = $clog2(INTERMEDIATE_SLOTS + 1);
	localparam int PIDX_W = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;
	localparam int SIDX_W = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;
	localparam int IIDX_W = (INTERMEDIATE_SLOTS > 1) ? $clog2(INTERMEDIATE_SLOTS) : 1;

	// Only the first four intermediates fit the summary word
	localparam int INTER_PACK = (INTERMEDIATE_SLOTS < 4) ? INTERMEDIATE_SLOTS : 4;

	// Value arithmetic
	localparam int            VALUE_W     = 21;
	localparam int            PROD_W      = 25;
	localparam int            DEC_BASE    = 10;
	localparam logic [VALUE_W-1:0] VALUE_LIMIT = 21'h10FFFF;
	localparam logic [VALUE_W-1:0] VALUE_SAT   = 21'h110000;

	// Byte codes
	localparam logic [7:0] BYTE_ESC   = 8'h1B;
	localparam logic [7:0] BYTE_CAN   = 8'h18;
	localparam logic [7:0] BYTE_SUB   = 8'h1A;
	localparam logic [7:0] BYTE_SEMI  = 8'h3B;
	localparam logic [7:0] BYTE_COLON = 8'h3A;

	// Record kinds
	localparam logic KIND_VALUE   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		BC_IGNORE,
		BC_DIGIT,
		BC_SEMI,
		BC_COLON,
		BC_INTER,
		BC_FINAL,
		BC_BAD,
		BC_CANCEL
	} byte_class_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} cpc_state_t;

	typedef struct packed {
		logic       new_sequence;
		logic [7:0] byte_req;
	} in_word_t;

	typedef struct packed {
		logic        record_kind;
		logic [1:0]  param_index;
		logic [1:0]  sub_index;
		logic [20:0] value;
		logic [7:0]  term_byte;
		logic [2:0]  param_count;
		logic [2:0]  intermediate_count;
		logic [31:0] intermediates;
		logic        had_subparams;
		logic        error;
		logic        escape_not_consumed;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic take;
		logic emit;
	} cpc_cmd_t;

	typedef struct packed {
		logic term;
		logic walk_done;
		logic slot_free;
	} cpc_status_t;

	function automatic byte_class_t classify(logic [7:0] b);
		byte_class_t c;
		c = BC_IGNORE;
		priority if (b >= 8'h30 && b <= 8'h39)
			c = BC_DIGIT;
		else if (b == BYTE_SEMI)
			c = BC_SEMI;
		else if (b == BYTE_COLON)
			c = BC_COLON;
		else if (b >= 8'h20 && b <= 8'h2F)
			c = BC_INTER;
		else if (b >= 8'h40 && b <= 8'h7E)
			c = BC_FINAL;
		else if ((b >= 8'h3C && b <= 8'h3F) || b >= 8'h80)
			c = BC_BAD;
		else if (b == BYTE_ESC || b == BYTE_CAN || b == BYTE_SUB)
			c = BC_CANCEL;
		else
			c = BC_IGNORE;
		return c;
	endfunction

endpackage

// File: src/cpc_ctrl.sv
// Controller of the CSI parameter collector: takes bytes while idle and
// steps the record walk after a terminating byte. Depends on cpc_pkg.
module cpc_ctrl import cpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cpc_status_t status,
	output cpc_cmd_t    cmd
);

	cpc_state_t state_q, state_d;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.take = in_valid && (state_q == ST_IDLE);
		cmd.emit = (state_q == ST_EMIT) && status.slot_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take && status.term)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// summary goes out on the step that finds the walk done
				if (status.slot_free && status.walk_done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: src/cpc_datapath.sv
// Datapath of the CSI parameter collector: accumulator, slot stores,
// record walk cursor and output register. Depends on cpc_pkg.
module cpc_datapath import cpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  in_word_t    in_data,
	input  cpc_cmd_t    cmd,
	output cpc_status_t status,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data
);

	// collection state
	logic [VALUE_W-1:0] acc_q;
	logic               ds_q;
	logic [PCNT_W-1:0]  pp_q;
	logic [SCNT_W-1:0]  sp_q;
	logic [ICNT_W-1:0]  ip_q;
	logic               sf_q;
	logic               err_q;
	logic [7:0]         fin_q;
	logic               esc_q;

	// stores
	logic [VALUE_W-1:0] value_q [PARAM_SLOTS][SUB_SLOTS];
	logic [SCNT_W-1:0]  cnt_q   [PARAM_SLOTS];
	logic [7:0]         inter_q [INTERMEDIATE_SLOTS];

	// walk cursor and output register
	logic [PCNT_W-1:0]  cur_p_q;
	logic [SIDX_W-1:0]  cur_s_q;
	logic               out_valid_q;
	out_word_t          out_q;

	// effective state after an optional new_sequence clear
	byte_class_t        cls;
	logic [VALUE_W-1:0] acc_b;
	logic               ds_b;
	logic [PCNT_W-1:0]  pp_b;
	logic [SCNT_W-1:0]  sp_b;
	logic [ICNT_W-1:0]  ip_b;
	logic               sf_b;
	logic               err_b;
	logic [PROD_W-1:0]  prod;
	logic               pos_full;

	logic [VALUE_W-1:0] acc_n;
	logic               ds_n;
	logic [PCNT_W-1:0]  pp_n;
	logic [SCNT_W-1:0]  sp_n;
	logic [ICNT_W-1:0]  ip_n;
	logic               sf_n;
	logic               err_n;
	logic [7:0]         fin_n;
	logic               esc_n;
	logic               st_we;
	logic               cnt_we;
	logic               inter_we;

	logic               walk_done;
	logic               s_last;
	logic [31:0]        packed_inter;
	out_word_t          rec;

	always_comb begin
		cls   = classify(in_data.byte_req);
		acc_b = in_data.new_sequence ? '0 : acc_q;
		ds_b  = in_data.new_sequence ? 1'b0 : ds_q;
		pp_b  = in_data.new_sequence ? '0 : pp_q;
		sp_b  = in_data.new_sequence ? '0 : sp_q;
		ip_b  = in_data.new_sequence ? '0 : ip_q;
		sf_b  = in_data.new_sequence ? 1'b0 : sf_q;
		err_b = in_data.new_sequence ? 1'b0 : err_q;

		prod = PROD_W'(acc_b) * PROD_W'(DEC_BASE) + PROD_W'(in_data.byte_req[3:0]);
		pos_full = (pp_b >= PCNT_W'(PARAM_SLOTS)) || (sp_b >= SCNT_W'(SUB_SLOTS));

		acc_n    = acc_b;
		ds_n     = ds_b;
		pp_n     = pp_b;
		sp_n     = sp_b;
		ip_n     = ip_b;
		sf_n     = sf_b;
		err_n    = err_b;
		fin_n    = fin_q;
		esc_n    = esc_q;
		st_we    = 1'b0;
		cnt_we   = 1'b0;
		inter_we = 1'b0;

		unique case (cls)
			BC_DIGIT: begin
				ds_n = 1'b1;
				if (acc_b >= VALUE_SAT) begin
					acc_n = VALUE_SAT;
				end else if (prod > PROD_W'(VALUE_LIMIT)) begin
					acc_n = VALUE_SAT;
					err_n = 1'b1;
				end else begin
					acc_n = prod[VALUE_W-1:0];
				end
			end
			BC_SEMI: begin
				if (pos_full) begin
					err_n = 1'b1;
				end else begin
					st_we  = 1'b1;
					cnt_we = 1'b1;
					pp_n   = pp_b + PCNT_W'(1);
					sp_n   = '0;
					acc_n  = '0;
					ds_n   = 1'b0;
				end
			end
			BC_COLON: begin
				if (pos_full) begin
					err_n = 1'b1;
				end else begin
					st_we = 1'b1;
					sp_n  = sp_b + SCNT_W'(1);
					acc_n = '0;
					ds_n  = 1'b0;
					sf_n  = 1'b1;
				end
			end
			BC_INTER: begin
				if (ip_b >= ICNT_W'(INTERMEDIATE_SLOTS)) begin
					err_n = 1'b1;
				end else begin
					inter_we = 1'b1;
					ip_n     = ip_b + ICNT_W'(1);
				end
			end
			BC_FINAL: begin
				// store the pending value as the last parameter
				if (ds_b) begin
					if (pos_full) begin
						err_n = 1'b1;
					end else begin
						st_we  = 1'b1;
						cnt_we = 1'b1;
						pp_n   = pp_b + PCNT_W'(1);
					end
				end
				fin_n = in_data.byte_req;
				esc_n = 1'b0;
			end
			BC_BAD: begin
				err_n = 1'b1;
			end
			BC_CANCEL: begin
				err_n = 1'b1;
				fin_n = in_data.byte_req;
				esc_n = (in_data.byte_req == BYTE_ESC);
			end
			BC_IGNORE: begin
			end
			default: begin
			end
		endcase
	end

	// walk: one value record per stored slot, then the summary
	always_comb begin
		walk_done = (cur_p_q >= pp_q);
		s_last    = ((SCNT_W'(cur_s_q) + SCNT_W'(1)) == cnt_q[cur_p_q[PIDX_W-1:0]]);

		packed_inter = '0;
		for (int k = 0; k < INTER_PACK; k++) begin
			if (ICNT_W'(k) < ip_q)
				packed_inter[8*k +: 8] = inter_q[k];
		end

		rec = '0;
		if (walk_done) begin
			rec.record_kind         = KIND_SUMMARY;
			rec.term_byte           = fin_q;
			rec.param_count         = 3'(pp_q);
			rec.intermediate_count  = 3'(ip_q);
			rec.intermediates       = packed_inter;
			rec.had_subparams       = sf_q;
			rec.error               = err_q;
			rec.escape_not_consumed = esc_q;
			rec.last                = 1'b1;
		end else begin
			rec.record_kind = KIND_VALUE;
			rec.param_index = 2'(cur_p_q);
			rec.sub_index   = 2'(cur_s_q);
			rec.value       = value_q[cur_p_q[PIDX_W-1:0]][cur_s_q];
		end

		status.term      = (cls == BC_FINAL) || (cls == BC_CANCEL);
		status.walk_done = walk_done;
		status.slot_free = !out_valid_q || out_ready;
	end

	// collection state and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			ds_q    <= 1'b0;
			pp_q    <= '0;
			sp_q    <= '0;
			ip_q    <= '0;
			sf_q    <= 1'b0;
			err_q   <= 1'b0;
			fin_q   <= '0;
			esc_q   <= 1'b0;
			cur_p_q <= '0;
			cur_s_q <= '0;
		end else if (cmd.take) begin
			acc_q <= acc_n;
			ds_q  <= ds_n;
			pp_q  <= pp_n;
			sp_q  <= sp_n;
			ip_q  <= ip_n;
			sf_q  <= sf_n;
			err_q <= err_n;
			fin_q <= fin_n;
			esc_q <= esc_n;
		end else if (cmd.emit) begin
			if (walk_done) begin
				// summary out: clear accumulator, counters, flags and cursor for the next sequence
				acc_q   <= '0;
				ds_q    <= 1'b0;
				pp_q    <= '0;
				sp_q    <= '0;
				ip_q    <= '0;
				sf_q    <= 1'b0;
				err_q   <= 1'b0;
				cur_p_q <= '0;
				cur_s_q <= '0;
			end else if (s_last) begin
				cur_p_q <= cur_p_q + PCNT_W'(1);
				cur_s_q <= '0;
			end else begin
				cur_s_q <= cur_s_q + SIDX_W'(1);
			end
		end
	end

	// stores, written at the current slot
	always_ff @(posedge clk) begin
		if (cmd.take && st_we)
			value_q[pp_b[PIDX_W-1:0]][sp_b[SIDX_W-1:0]] <= acc_b;
		if (cmd.take && cnt_we)
			cnt_q[pp_b[PIDX_W-1:0]] <= sp_b + SCNT_W'(1);
		if (cmd.take && inter_we)
			inter_q[ip_b[IIDX_W-1:0]] <= in_data.byte_req;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_q <= rec;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: src/csi_parameter_collector_unit.sv
// Top level of the CSI parameter collector: controller plus datapath.
// Depends on cpc_pkg, cpc_ctrl and cpc_datapath.
//
//   channel  | direction | handshake            | word
//   ---------+-----------+----------------------+--------------------------------
//   in       | input     | in_valid / in_ready  | in_word_t  (new_sequence, byte)
//   out      | output    | out_valid / out_ready| out_word_t (value or summary)
//
// Flow: bytes that do not end the sequence are taken one per cycle while idle.
// A final byte, ESC, CAN or SUB is taken, then the record walk sends one record
// per cycle while out_ready is high: (stored values + 1) records, at most
// PARAM_SLOTS * SUB_SLOTS + 1. The walk over the value store sets that figure.
// Reset: arst_n clears the controller and all collection counters at once;
// the value store and sub-parameter counts hold nothing until written.
// Stalls: out_ready low freezes the walk; in_ready is low from the accept of a
// terminating byte until its summary word is loaded into the output register.
module csi_parameter_collector_unit import cpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	cpc_cmd_t    cmd;
	cpc_status_t status;

	// Sequence the byte intake and the record walk
	cpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Hold the accumulator, slot stores, cursor and output register
	cpc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: src/cpc_checker.sv
// Port checker for the CSI parameter collector, bound to the top level.
// Depends on cpc_pkg.
module cpc_checker import cpc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// a stalled word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("out_data changed while stalled");

	// a value record means the summary is still to come, so no byte is taken
	a_no_take_mid_walk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.record_kind == KIND_VALUE |-> !in_ready)
		else $error("input ready during record walk");

	// a final byte starts the walk
	a_final_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.byte_req >= 8'h40 && in_data.byte_req <= 8'h7E
		|=> !in_ready)
		else $error("input ready right after final byte");

	// values never exceed the saturation value VALUE_SAT; last marks the summary only
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == out_data.record_kind)
			&& (out_data.value <= VALUE_SAT))
		else $error("bad record fields");

endmodule

bind csi_parameter_collector_unit cpc_checker u_cpc_checker (.*);

// File: tb/cpc_record_checker.sv
// Scoreboard for the CSI parameter collector: watches both channels, predicts
// the record words of each accepted byte and compares them with the output.
// Depends on cpc_pkg.
module cpc_record_checker import cpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_data,
	output int        outstanding,
	output int        mismatches,
	output int        words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] DIGIT_LO    = 8'h30;
	localparam logic [7:0] DIGIT_HI    = 8'h39;
	localparam logic [7:0] INTER_LO    = 8'h20;
	localparam logic [7:0] INTER_HI    = 8'h2F;
	localparam logic [7:0] FINAL_LO    = 8'h40;
	localparam logic [7:0] FINAL_HI    = 8'h7E;
	localparam logic [7:0] RESERVED_LO = 8'h3C;
	localparam logic [7:0] RESERVED_HI = 8'h3F;
	localparam logic [7:0] HIGH_HALF   = 8'h80;

	// Shadow of the collection state
	logic [VALUE_W-1:0] accum;
	bit                 digit_pending;
	int unsigned        param_pos;
	int unsigned        sub_pos;
	logic [VALUE_W-1:0] stored_values [PARAM_SLOTS][SUB_SLOTS];
	int unsigned        sub_total [PARAM_SLOTS];
	logic [7:0]         inter_bytes [INTERMEDIATE_SLOTS];
	int unsigned        inter_pos;
	bit                 colon_seen;
	bit                 error_seen;

	out_word_t records_due [$];
	int        error_tally = 0;
	int        word_tally = 0;

	task automatic clear_collection();
		accum = '0;
		digit_pending = 0;
		param_pos = 0;
		sub_pos = 0;
		foreach (stored_values[p, s])
			stored_values[p][s] = '0;
		foreach (sub_total[p])
			sub_total[p] = 0;
		foreach (inter_bytes[i])
			inter_bytes[i] = '0;
		inter_pos = 0;
		colon_seen = 0;
		error_seen = 0;
	endtask

	// Queue one value word per stored value, then the summary word
	task automatic emit_records(input logic [7:0] fin, input bit esc);
		out_word_t w;
		logic [31:0] packed_inter;
		packed_inter = '0;
		for (int p = 0; p < param_pos && p < PARAM_SLOTS; p++) begin
			for (int s = 0; s < sub_total[p] && s < SUB_SLOTS; s++) begin
				w = '0;
				w.record_kind = KIND_VALUE;
				w.param_index = p[1:0];
				w.sub_index = s[1:0];
				w.value = stored_values[p][s];
				records_due.push_back(w);
			end
		end
		for (int s = 0; s < inter_pos && s < INTERMEDIATE_SLOTS && s < 4; s++)
			packed_inter[8*s +: 8] = inter_bytes[s];
		w = '0;
		w.record_kind = KIND_SUMMARY;
		w.term_byte = fin;
		w.param_count = param_pos[2:0];
		w.intermediate_count = inter_pos[2:0];
		w.intermediates = packed_inter;
		w.had_subparams = colon_seen;
		w.error = error_seen;
		w.escape_not_consumed = esc;
		w.last = 1'b1;
		records_due.push_back(w);
		clear_collection();
	endtask

	task automatic collect_byte(input in_word_t w);
		logic [7:0] b;
		int unsigned grown;
		b = w.byte_req;
		if (w.new_sequence)
			clear_collection();
		if (b >= DIGIT_LO && b <= DIGIT_HI) begin
			if (accum >= VALUE_SAT) begin
				accum = VALUE_SAT;
			end else begin
				grown = accum * DEC_BASE + (b - DIGIT_LO);
				if (grown > VALUE_LIMIT) begin
					error_seen = 1;
					accum = VALUE_SAT;
				end else begin
					accum = grown[VALUE_W-1:0];
				end
			end
			digit_pending = 1;
		end else if (b == BYTE_SEMI) begin
			if (param_pos >= PARAM_SLOTS || sub_pos >= SUB_SLOTS) begin
				error_seen = 1;
			end else begin
				sub_total[param_pos] = sub_pos + 1;
				stored_values[param_pos][sub_pos] = accum;
				param_pos++;
				accum = '0;
				digit_pending = 0;
				sub_pos = 0;
			end
		end else if (b == BYTE_COLON) begin
			if (param_pos >= PARAM_SLOTS || sub_pos >= SUB_SLOTS) begin
				error_seen = 1;
			end else begin
				stored_values[param_pos][sub_pos] = accum;
				sub_pos++;
				accum = '0;
				digit_pending = 0;
				colon_seen = 1;
			end
		end else if (b >= INTER_LO && b <= INTER_HI) begin
			if (inter_pos >= INTERMEDIATE_SLOTS)
				error_seen = 1;
			else
				inter_bytes[inter_pos++] = b;
		end else if (b >= FINAL_LO && b <= FINAL_HI) begin
			if (digit_pending) begin
				if (param_pos >= PARAM_SLOTS || sub_pos >= SUB_SLOTS) begin
					error_seen = 1;
				end else begin
					sub_total[param_pos] = sub_pos + 1;
					stored_values[param_pos][sub_pos] = accum;
					param_pos++;
				end
			end
			emit_records(b, 1'b0);
		end else if ((b >= RESERVED_LO && b <= RESERVED_HI) || b >= HIGH_HALF) begin
			error_seen = 1;
		end else if (b == BYTE_ESC || b == BYTE_CAN || b == BYTE_SUB) begin
			error_seen = 1;
			emit_records(b, b == BYTE_ESC);
		end
	endtask

	task automatic compare_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			error_tally++;
			if (error_tally <= 10)
				$display("word %0d, %s: expected 0x%0h, got 0x%0h",
					word_tally, field, want, got);
		end
	endtask

	task automatic check_word(input out_word_t got);
		out_word_t want;
		word_tally++;
		if (records_due.size() == 0) begin
			error_tally++;
			if (error_tally <= 10)
				$display("word %0d arrived with nothing expected: 0x%0h", word_tally, got);
		end else begin
			want = records_due.pop_front();
			compare_field("record_kind", 32'(got.record_kind), 32'(want.record_kind));
			compare_field("param_index", 32'(got.param_index), 32'(want.param_index));
			compare_field("sub_index", 32'(got.sub_index), 32'(want.sub_index));
			compare_field("value", 32'(got.value), 32'(want.value));
			compare_field("term_byte", 32'(got.term_byte), 32'(want.term_byte));
			compare_field("param_count", 32'(got.param_count), 32'(want.param_count));
			compare_field("intermediate_count", 32'(got.intermediate_count),
				32'(want.intermediate_count));
			compare_field("intermediates", got.intermediates, want.intermediates);
			compare_field("had_subparams", 32'(got.had_subparams),
				32'(want.had_subparams));
			compare_field("error", 32'(got.error), 32'(want.error));
			compare_field("escape_not_consumed", 32'(got.escape_not_consumed),
				32'(want.escape_not_consumed));
			compare_field("last", 32'(got.last), 32'(want.last));
		end
	endtask

	// Output words leave before a byte accepted on the same edge can add any
	always @(posedge clk) begin
		if (!arst_n) begin
			clear_collection();
			records_due.delete();
		end else begin
			if (out_valid && out_ready)
				check_word(out_data);
			if (in_valid && in_ready)
				collect_byte(in_data);
		end
		outstanding <= records_due.size();
		mismatches <= error_tally;
		words_checked <= word_tally;
	end

endmodule

// File: tb/testbench.sv
// Top of the CSI parameter collector testbench: clock, reset, byte stimulus,
// output back-pressure and the verdict. Depends on cpc_pkg,
// csi_parameter_collector_unit and cpc_record_checker.
module testbench import cpc_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_BYTES = 430;
	localparam int CALM_FROM   = 370;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	int outstanding;
	int mismatches;
	int words_checked;

	// Idle-free tail of the run: both sides stop pausing
	bit calm = 0;
	int counted_bytes = 0;
	int sequences_sent = 0;

	csi_parameter_collector_unit dut (.*);
	cpc_record_checker checker_i (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hold the input word back for a number of cycles
	task automatic idle_for(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Offer one word and hold it until the block takes it; valid stays high
	// afterwards so that the next word can follow back to back
	task automatic push_word(input logic fresh, input logic [7:0] b);
		if (!calm && $urandom_range(0, 5) == 0)
			idle_for($urandom_range(1, 19));
		in_data <= '{new_sequence: fresh, byte_req: b};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		counted_bytes++;
	endtask

	task automatic send_text(input logic fresh, input string s);
		for (int i = 0; i < s.len(); i++)
			push_word(fresh && i == 0, s[i]);
	endtask

	// Drop valid and wait for every predicted record word to come out
	task automatic wait_for_records();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Build one sequence: mostly well-formed parameter strings with random
	// digits, separators, intermediates and an ending byte; the rest is noise
	task automatic random_sequence();
		logic [7:0] seq [$];
		int nparam;
		int nsub;
		int ndig;
		int pick;
		logic fresh;
		logic [7:0] b;
		pick = $urandom_range(0, 9);
		fresh = 1'($urandom_range(0, 1));
		if (pick < 7) begin
			nparam = $urandom_range(0, 5);
			for (int p = 0; p < nparam; p++) begin
				nsub = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
				for (int s = 0; s < nsub; s++) begin
					if (s > 0)
						seq.push_back(BYTE_COLON);
					pick = $urandom_range(0, 9);
					// Mostly short values, now and then long enough to saturate
					if (pick == 0)
						ndig = 0;
					else if (pick <= 6)
						ndig = $urandom_range(1, 3);
					else if (pick <= 8)
						ndig = $urandom_range(4, 6);
					else
						ndig = $urandom_range(7, 8);
					repeat (ndig) seq.push_back(8'("0" + $urandom_range(0, 9)));
				end
				if (p < nparam - 1 || $urandom_range(0, 3) == 0)
					seq.push_back(BYTE_SEMI);
			end
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 5))
					seq.push_back(8'($urandom_range(8'h20, 8'h2F)));
			// Drop a stray byte somewhere now and then
			if ($urandom_range(0, 5) == 0)
				seq.insert($urandom_range(0, seq.size()), 8'($urandom_range(0, 255)));
			pick = $urandom_range(0, 9);
			if (pick == 0)
				seq.push_back(BYTE_ESC);
			else if (pick == 1)
				seq.push_back(BYTE_CAN);
			else if (pick == 2)
				seq.push_back(BYTE_SUB);
			else
				seq.push_back(8'($urandom_range(8'h40, 8'h7E)));
		end else begin
			repeat ($urandom_range(1, 12)) seq.push_back(8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < seq.size(); i++) begin
			b = seq[i];
			push_word((i == 0) ? fresh : ($urandom_range(0, 39) == 0), b);
		end
		sequences_sent++;
	endtask

	// Output side: ready in runs of random length, with stalls of random length
	initial begin : sink_pacing
		int hold;
		forever begin
			@(posedge clk);
			if (calm || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
				hold = $urandom_range(1, 30);
			end else begin
				out_ready <= 1'b0;
				hold = $urandom_range(1, 19);
			end
			repeat (hold - 1) @(posedge clk);
		end
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reserved and high bytes, an ignored control, DEL, one intermediate
		// too many, lowest final byte
		push_word(1'b1, "?");
		push_word(1'b0, 8'hFF);
		push_word(1'b0, 8'h00);
		push_word(1'b0, 8'h7F);
		send_text(1'b0, " /*+,@");
		// Saturating value, all parameter slots used, then ';' and ':' past
		// the end, highest final byte
		send_text(1'b0, "1114112;;;;;:~");
		// All sub-parameter slots used with a value still pending at the end
		send_text(1'b1, "9:9:9:9:9m");
		// Cancel bytes, one of them with a fresh start
		push_word(1'b0, BYTE_ESC);
		push_word(1'b1, BYTE_CAN);
		push_word(1'b0, BYTE_SUB);
		wait_for_records();

		while (counted_bytes < TOTAL_BYTES) begin
			random_sequence();
			if (counted_bytes >= CALM_FROM)
				calm <= 1'b1;
			else if ($urandom_range(0, 11) == 0)
				wait_for_records();
		end

		wait_for_records();
		repeat (40) @(posedge clk);
		$display("Sent %0d bytes in all, %0d random sequences after the directed ones;",
			counted_bytes, sequences_sent);
		$display("checked %0d output words, %0d field mismatches.",
			words_checked, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Worst case is far below this: every word stalled, every byte delayed
	initial begin : watchdog
		#(3_000_000);
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: csi_parameter_collector_unit.f
src/cpc_pkg.sv
src/cpc_ctrl.sv
src/cpc_datapath.sv
src/csi_parameter_collector_unit.sv
src/cpc_checker.sv
tb/cpc_record_checker.sv
tb/testbench.sv
